// ----- src/htwa_pkg.sv -----
`default_nettype none
package htwa_pkg;
    localparam int TimeW = 47;
    localparam int DiffW = 48;
    localparam int CntW = 16;
    localparam int DefMaxTriggers = 16;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_HIT = 2'd1;
    localparam logic [1:0] CMD_END = 2'd2;

    localparam logic [1:0] KIND_HIT = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [1:0] DISP_ASSIGNED = 2'd0;
    localparam logic [1:0] DISP_OUTSIDE = 2'd1;
    localparam logic [1:0] DISP_NONE = 2'd2;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_PRE = 2'd1;
    localparam logic [1:0] REG_POST = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;       // store trigger
        logic hit_start;  // capture hit, clear scan state
        logic scan_step;  // compare entry scan_idx
        logic hit_commit; // update counters of nearest
        logic sum_start;  // clear with-hits counter
        logic cnt_step;   // count entry scan_idx
        logic sum_step;   // emit summary of entry scan_idx and clear it
        logic clear;      // clear trigger count
    } htwa_cmd_t;

    typedef struct packed {
        logic stored_zero;
        logic table_full;
    } htwa_status_t;
endpackage
`default_nettype wire

// ----- src/htwa_datapath.sv -----
`default_nettype none
module htwa_datapath #(
    parameter int MAX_TRIGGERS = htwa_pkg::DefMaxTriggers,
    parameter int IW = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1,
    parameter int CW = $clog2(MAX_TRIGGERS + 1)
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire htwa_pkg::htwa_cmd_t cmd,
    input  wire logic [IW-1:0] scan_idx,
    output htwa_pkg::htwa_status_t status,
    output logic [CW-1:0] count_out,
    input  wire logic [46:0] trigger_time,
    input  wire logic [46:0] first_cell_time,
    input  wire logic [5:0] trigger_cell,
    input  wire logic signed [30:0] hit_offset,
    input  wire logic [29:0] pre_window,
    input  wire logic [29:0] post_window,
    input  wire logic [19:0] sample_period,
    output logic [1:0] r_disposition,
    output logic [3:0] r_nearest,
    output logic [4:0] r_window_count,
    output logic [46:0] r_hit_time,
    output logic signed [47:0] r_diff,
    output logic r_ambiguous,
    output logic [15:0] r_hits,
    output logic [15:0] r_amb_hits,
    output logic [4:0] r_with
);
    import htwa_pkg::*;

    logic [46:0] table_mem [MAX_TRIGGERS];
    logic [15:0] hits_reg [MAX_TRIGGERS];
    logic [15:0] amb_reg [MAX_TRIGGERS];
    logic [CW-1:0] count_reg;
    logic [46:0] ht_reg;
    logic [IW-1:0] near_reg;
    logic signed [49:0] ndelta_reg;
    logic [48:0] best_reg;
    logic [CW-1:0] inside_reg;
    logic [CW-1:0] with_reg;

    logic [26:0] prod;
    logic [47:0] ht_sum;
    logic [46:0] ht_sat;
    logic signed [49:0] delta;
    logic [48:0] span_abs;
    logic in_win;
    logic near_in;
    logic signed [49:0] pre_s, post_s;

    assign prod = 27'(trigger_cell) * 27'(sample_period);
    assign ht_sum = {1'b0, first_cell_time} + 48'(prod);
    assign ht_sat = ht_sum[47] ? '1 : ht_sum[46:0];
    assign pre_s = -$signed({20'd0, pre_window});
    assign post_s = $signed({20'd0, post_window});
    assign delta = $signed({3'd0, ht_reg}) - ($signed({3'd0, table_mem[scan_idx]})
                   + 50'(hit_offset));
    assign span_abs = delta[49] ? 49'(-delta) : 49'(delta);
    assign in_win = delta >= pre_s && delta <= post_s;
    assign near_in = ndelta_reg >= pre_s && ndelta_reg <= post_s;

    assign status.stored_zero = count_reg == '0;
    assign status.table_full = count_reg == CW'(MAX_TRIGGERS);
    assign count_out = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < MAX_TRIGGERS; i++) begin
                hits_reg[i] <= '0;
                amb_reg[i] <= '0;
            end
        end else begin
            if (cmd.load && !status.table_full) begin
                table_mem[count_reg[IW-1:0]] <= trigger_time;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.hit_commit && !status.stored_zero && near_in) begin
                if (hits_reg[near_reg] != '1) hits_reg[near_reg] <= hits_reg[near_reg] + 1'b1;
                if (inside_reg > CW'(1) && amb_reg[near_reg] != '1)
                    amb_reg[near_reg] <= amb_reg[near_reg] + 1'b1;
            end
            if (cmd.sum_step) begin
                hits_reg[scan_idx] <= '0;
                amb_reg[scan_idx] <= '0;
            end
            if (cmd.clear) count_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hit_start) begin
            ht_reg <= ht_sat;
            inside_reg <= '0;
        end
        if (cmd.scan_step) begin
            if (scan_idx == '0 || span_abs < best_reg) begin
                best_reg <= span_abs;
                near_reg <= scan_idx;
                ndelta_reg <= delta;
            end
            if (in_win) inside_reg <= inside_reg + 1'b1;
        end
        if (cmd.sum_start) with_reg <= '0;
        if (cmd.cnt_step && hits_reg[scan_idx] != '0) with_reg <= with_reg + 1'b1;
    end

    logic signed [47:0] diff_sat;
    always_comb begin
        if (ndelta_reg > 50'sh7FFFFFFFFFFF) diff_sat = 48'sh7FFFFFFFFFFF;
        else if (ndelta_reg < -50'sh800000000000) diff_sat = 48'sh800000000000;
        else diff_sat = ndelta_reg[47:0];
    end

    // hit-result fields (valid at hit_commit) and summary fields (at sum_step)
    assign r_disposition = status.stored_zero ? DISP_NONE :
                           (near_in ? DISP_ASSIGNED : DISP_OUTSIDE);
    assign r_nearest = cmd.sum_step ? 4'(scan_idx) : 4'(near_reg);
    assign r_window_count = 5'(inside_reg);
    assign r_hit_time = ht_reg;
    assign r_diff = diff_sat;
    assign r_ambiguous = near_in && inside_reg > CW'(1);
    assign r_hits = hits_reg[scan_idx];
    assign r_amb_hits = amb_reg[scan_idx];
    assign r_with = 5'(with_reg);
endmodule
`default_nettype wire

// ----- src/htwa_ctrl.sv -----
`default_nettype none
module htwa_ctrl #(
    parameter int MAX_TRIGGERS = htwa_pkg::DefMaxTriggers,
    parameter int IW = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1,
    parameter int CW = $clog2(MAX_TRIGGERS + 1)
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic [1:0] in_command,
    input  wire htwa_pkg::htwa_status_t status,
    input  wire logic [CW-1:0] count,
    output htwa_pkg::htwa_cmd_t cmd,
    output logic [IW-1:0] scan_idx,
    output logic out_load,
    output logic [1:0] out_kind,
    output logic out_last,
    input  wire logic out_free
);
    import htwa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_HIT = 6'b000100,
        S_CNT = 6'b001000, S_SUM = 6'b010000, S_EMPTY = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lim;
    logic scan_last;

    assign lim = count;
    assign scan_idx = idx_reg;
    assign scan_last = CW'(idx_reg) + 1'b1 == lim;
    assign in_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        cmd = '0;
        out_load = 1'b0;
        out_kind = KIND_HIT;
        out_last = 1'b1;
        case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                if (in_valid) begin
                    case (in_command)
                        CMD_LOAD: cmd.load = 1'b1;
                        CMD_HIT: begin
                            cmd.hit_start = 1'b1;
                            state_next = status.stored_zero ? S_HIT : S_SCAN;
                        end
                        CMD_END: begin
                            cmd.sum_start = 1'b1;
                            state_next = status.stored_zero ? S_EMPTY : S_CNT;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (scan_last) state_next = S_HIT;
            end
            S_HIT: if (out_free) begin
                cmd.hit_commit = 1'b1;
                out_load = 1'b1;
                state_next = S_IDLE;
            end
            S_CNT: begin
                cmd.cnt_step = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (scan_last) begin
                    idx_next = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                out_kind = KIND_SUMMARY;
                out_last = scan_last;
                if (out_free) begin
                    cmd.sum_step = 1'b1;
                    out_load = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (scan_last) begin
                        cmd.clear = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMPTY: begin
                out_kind = KIND_EMPTY;
                if (out_free) begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end
endmodule
`default_nettype wire

// ----- src/hit_trigger_window_associator.sv -----
`default_nettype none
// Hit-to-trigger window associator. Load triggers (command 0), classify hits
// (command 1) against the stored triggers, and close the event (command 2),
// which emits one summary per stored trigger and clears the table. A hit is
// classified by one shared comparator that walks the trigger table one entry
// per cycle; an end of event makes one counting pass, then emits one summary
// a cycle while the output register is free, or one empty record with no
// triggers stored. Results sit in an output register; a result that finds
// it still full holds in the controller, and no new request is taken until
// it moves on. Up to MAX_TRIGGERS triggers are kept; later loads are
// dropped.
module hit_trigger_window_associator #(
    parameter int MAX_TRIGGERS = htwa_pkg::DefMaxTriggers
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [30:0] cfg_data,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire logic [1:0] s_command,
    input  wire logic [46:0] s_trigger_time,
    input  wire logic [46:0] s_first_cell_time,
    input  wire logic [5:0] s_trigger_cell,
    output logic m_valid,
    input  wire logic m_ready,
    output logic [1:0] m_record_kind,
    output logic [1:0] m_disposition,
    output logic [3:0] m_nearest_trigger,
    output logic [4:0] m_window_count,
    output logic [46:0] m_hit_time,
    output logic signed [47:0] m_hit_minus_reference,
    output logic m_ambiguous,
    output logic [15:0] m_trigger_hits,
    output logic [15:0] m_trigger_ambiguous_hits,
    output logic [4:0] m_hit_trigger_total,
    output logic m_last
);
    import htwa_pkg::*;
    localparam int IW = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
    localparam int CW = $clog2(MAX_TRIGGERS + 1);

    // configuration registers
    logic signed [30:0] offset_reg;
    logic [29:0] pre_reg, post_reg;
    logic [19:0] period_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            pre_reg <= '0;
            post_reg <= '0;
            period_reg <= 20'd160;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OFFSET: offset_reg <= cfg_data;
                REG_PRE: pre_reg <= cfg_data[29:0];
                REG_POST: post_reg <= cfg_data[29:0];
                REG_PERIOD: period_reg <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    htwa_cmd_t cmd;
    htwa_status_t status;
    logic [IW-1:0] scan_idx;
    logic out_load, out_last, out_free;
    logic [1:0] out_kind;
    logic [CW-1:0] count;
    logic [1:0] r_disp;
    logic [3:0] r_near;
    logic [4:0] r_wc, r_with;
    logic [46:0] r_ht;
    logic signed [47:0] r_diff;
    logic r_amb;
    logic [15:0] r_hits, r_amb_hits;
    logic s_ready_int;
    logic hit_rec, hit_full, sum_rec;

    // output register frees when empty or being taken
    assign out_free = !m_valid || m_ready;
    // accept new request only while the controller is idle
    assign s_ready = s_ready_int;

    htwa_ctrl #(.MAX_TRIGGERS(MAX_TRIGGERS)) u_ctrl (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready_int),
        .in_command(s_command), .status, .count, .cmd, .scan_idx,
        .out_load, .out_kind, .out_last, .out_free
    );

    htwa_datapath #(.MAX_TRIGGERS(MAX_TRIGGERS)) u_dp (
        .aclk, .aresetn, .cmd, .scan_idx, .status, .count_out(count),
        .trigger_time(s_trigger_time), .first_cell_time(s_first_cell_time),
        .trigger_cell(s_trigger_cell), .hit_offset(offset_reg),
        .pre_window(pre_reg), .post_window(post_reg), .sample_period(period_reg),
        .r_disposition(r_disp), .r_nearest(r_near), .r_window_count(r_wc),
        .r_hit_time(r_ht), .r_diff, .r_ambiguous(r_amb), .r_hits,
        .r_amb_hits, .r_with
    );

    // which fields the record kind carries; the rest load as zero
    assign hit_rec = out_kind == KIND_HIT;
    assign hit_full = hit_rec && !status.stored_zero;
    assign sum_rec = out_kind == KIND_SUMMARY;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid <= 1'b0;
        else if (out_load) m_valid <= 1'b1;
        else if (m_ready) m_valid <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_record_kind <= out_kind;
            m_last <= out_last;
            m_disposition <= hit_rec ? r_disp : '0;
            m_nearest_trigger <= (hit_full || sum_rec) ? r_near : '0;
            m_window_count <= hit_full ? r_wc : '0;
            m_hit_time <= hit_rec ? r_ht : '0;
            m_hit_minus_reference <= hit_full ? r_diff : '0;
            m_ambiguous <= hit_full && r_amb;
            m_trigger_hits <= sum_rec ? r_hits : '0;
            m_trigger_ambiguous_hits <= sum_rec ? r_amb_hits : '0;
            m_hit_trigger_total <= sum_rec ? r_with : '0;
        end
    end

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_record_kind))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(MAX_TRIGGERS))
        else $error("trigger count past capacity");
`endif
endmodule
`default_nettype wire
